// ===== hdl/compass_vector_sum_core_defines.svh =====
// Assertion macros for the files that check their own logic.
`ifndef COMPASS_VECTOR_SUM_CORE_DEFINES_SVH
`define COMPASS_VECTOR_SUM_CORE_DEFINES_SVH

// Asserts that a condition implies a consequence on the following edge.
`define CVS_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

// Asserts that a condition implies a consequence on the same edge.
`define CVS_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cvs_pkg.sv =====
`default_nettype none
package cvs_pkg;

  typedef struct packed {
    logic [13:0] first_magnitude;
    logic [9:0]  first_angle;
    logic        first_north;
    logic        first_east;
    logic [13:0] second_magnitude;
    logic [9:0]  second_angle;
    logic        second_north;
    logic        second_east;
  } in_item_t;

  typedef struct packed {
    logic [17:0] sum_magnitude;
    logic [16:0] sum_angle;
    logic        sum_north;
    logic        sum_east;
  } out_item_t;

  localparam int unsigned MagMax    = 10099;
  localparam int unsigned AngleMax  = 900;
  localparam logic [23:0] GainQ24   = 24'd10188014;
  localparam int unsigned MagOutMax = 262143;
  localparam int unsigned TableLen  = 32;

  // Arctangent of 2^-i in degrees, scaled by 2^24.
  function automatic logic [29:0] atan_q24(input logic [4:0] idx);
    logic [29:0] t;
    case (idx)
      5'd0:  t = 30'd754974720;
      5'd1:  t = 30'd445687602;
      5'd2:  t = 30'd235489088;
      5'd3:  t = 30'd119537938;
      5'd4:  t = 30'd60000934;
      5'd5:  t = 30'd30029717;
      5'd6:  t = 30'd15018523;
      5'd7:  t = 30'd7509720;
      5'd8:  t = 30'd3754917;
      5'd9:  t = 30'd1877466;
      5'd10: t = 30'd938734;
      5'd11: t = 30'd469367;
      5'd12: t = 30'd234684;
      5'd13: t = 30'd117342;
      5'd14: t = 30'd58671;
      5'd15: t = 30'd29335;
      5'd16: t = 30'd14668;
      5'd17: t = 30'd7334;
      5'd18: t = 30'd3667;
      5'd19: t = 30'd1833;
      5'd20: t = 30'd917;
      5'd21: t = 30'd458;
      5'd22: t = 30'd229;
      5'd23: t = 30'd115;
      5'd24: t = 30'd57;
      5'd25: t = 30'd29;
      5'd26: t = 30'd14;
      5'd27: t = 30'd7;
      5'd28: t = 30'd4;
      5'd29: t = 30'd2;
      5'd30: t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

  // Stage angle brought to the requested number of fraction bits, round half up.
  function automatic logic [29:0] stage_angle(input int idx, input int fbits);
    logic [29:0] t;
    int s;
    t = atan_q24(idx[4:0]);
    s = 24 - fbits;
    if (s <= 0) begin
      return t;
    end
    return 30'((31'(t) + (31'd1 << (s - 1))) >> s);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cvs_cell.sv =====
`default_nettype none
// One CORDIC micro-rotation, registered. Mode 0 rotates towards z = 0,
// mode 1 vectors towards y = 0. Sideband rides along with the data.
module cvs_cell #(
  parameter int W     = 40,
  parameter int ZW    = 32,
  parameter int SB    = 8,
  parameter int SHIFT = 0,
  parameter bit VECT  = 1'b0,
  parameter logic [29:0] ANGLE = 30'd0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 vld_in,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic signed [ZW-1:0] z_in,
  input  wire logic [SB-1:0]        sb_in,
  output logic                      vld_out,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic signed [ZW-1:0]      z_out,
  output logic [SB-1:0]             sb_out
);
  logic signed [W-1:0]  x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_nxt, ang;
  logic                 plus;
  logic                 vld_r;
  logic signed [W-1:0]  x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [SB-1:0]        sb_r;

  always_comb begin
    xs   = x_in >>> SHIFT;
    ys   = y_in >>> SHIFT;
    ang  = ZW'(ANGLE);
    plus = VECT ? (y_in <= 0) : (z_in >= 0);
    if (plus) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ang;
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    sb_r <= sb_in;
  end

  assign vld_out = vld_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;
  assign sb_out  = sb_r;
endmodule
`default_nettype wire

// ===== hdl/cvs_chain.sv =====
`default_nettype none
// A row of CORDIC cells, one per stage.
module cvs_chain #(
  parameter int STAGES = 20,
  parameter int FBITS  = 16,
  parameter int W      = 40,
  parameter int ZW     = 32,
  parameter int SB     = 8,
  parameter bit VECT   = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 vld_in,
  input  wire logic signed [W-1:0]  x_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic signed [ZW-1:0] z_in,
  input  wire logic [SB-1:0]        sb_in,
  output logic                      vld_out,
  output logic signed [W-1:0]       x_out,
  output logic signed [W-1:0]       y_out,
  output logic signed [ZW-1:0]      z_out,
  output logic [SB-1:0]             sb_out
);
  logic                 vld [STAGES+1];
  logic signed [W-1:0]  xc  [STAGES+1];
  logic signed [W-1:0]  yc  [STAGES+1];
  logic signed [ZW-1:0] zc  [STAGES+1];
  logic [SB-1:0]        sbc [STAGES+1];

  assign vld[0] = vld_in;
  assign xc[0]  = x_in;
  assign yc[0]  = y_in;
  assign zc[0]  = z_in;
  assign sbc[0] = sb_in;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    cvs_cell #(
      .W(W), .ZW(ZW), .SB(SB), .SHIFT(i), .VECT(VECT),
      .ANGLE(cvs_pkg::stage_angle(i, FBITS))
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_in(vld[i]), .x_in(xc[i]), .y_in(yc[i]), .z_in(zc[i]), .sb_in(sbc[i]),
      .vld_out(vld[i+1]), .x_out(xc[i+1]), .y_out(yc[i+1]), .z_out(zc[i+1]),
      .sb_out(sbc[i+1])
    );
  end

  assign vld_out = vld[STAGES];
  assign x_out   = xc[STAGES];
  assign y_out   = yc[STAGES];
  assign z_out   = zc[STAGES];
  assign sb_out  = sbc[STAGES];
endmodule
`default_nettype wire

// ===== hdl/compass_vector_sum_core.sv =====
// Item path: stages 1-2, rotation rows, stages 3-4, vectoring row, stages 5-6, output.
// Throughput: one item per cycle; busy stays low, the pipeline of cells sets the rate.
// Each stage of all three CORDIC rows is one cell with its own register.
// Reset (synchronous, rst_n low) clears every valid bit; no result is then in flight.
// The receiver cannot stall: out_valid is high for exactly one cycle per item.
`default_nettype none
`include "compass_vector_sum_core_defines.svh"
module compass_vector_sum_core #(
  parameter int CORDIC_STAGES = 20,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire cvs_pkg::in_item_t in_item,
  output logic                   out_valid,
  output cvs_pkg::out_item_t     out_item
);
  localparam int NST = (CORDIC_STAGES < cvs_pkg::TableLen) ? CORDIC_STAGES
                                                           : cvs_pkg::TableLen;
  // Lengths: 14-bit magnitude, F fractions, CORDIC growth and sum headroom.
  localparam int W  = FRACTION_BITS + 20;
  localparam int ZW = FRACTION_BITS + 10;
  localparam int PW = W + 25;
  // Reciprocal of ten, exact for every scaled input angle below 2^ZW.
  localparam logic [ZW-1:0] RecipTen =
    ZW'(((64'd1 << (FRACTION_BITS + 13)) + 64'd9) / 64'd10);

  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Stage 1: clamp and scale inputs.
  logic          s1_vld_r;
  logic [13:0]   m1_r, m2_r;
  logic [ZW-1:0] z1_r, z2_r;
  logic [1:0]    f1_r, f2_r;
  logic [13:0]   m1c, m2c;
  logic [9:0]    a1c, a2c;
  logic [ZW-1:0]   v1, v2;
  logic [2*ZW-1:0] q1, q2;

  always_comb begin
    m1c = (in_item.first_magnitude > 14'(cvs_pkg::MagMax)) ? 14'(cvs_pkg::MagMax)
                                                           : in_item.first_magnitude;
    m2c = (in_item.second_magnitude > 14'(cvs_pkg::MagMax)) ? 14'(cvs_pkg::MagMax)
                                                            : in_item.second_magnitude;
    a1c = (in_item.first_angle > 10'(cvs_pkg::AngleMax)) ? 10'(cvs_pkg::AngleMax)
                                                         : in_item.first_angle;
    a2c = (in_item.second_angle > 10'(cvs_pkg::AngleMax)) ? 10'(cvs_pkg::AngleMax)
                                                          : in_item.second_angle;
    v1  = (ZW'(a1c) << FRACTION_BITS) + ZW'(5);
    v2  = (ZW'(a2c) << FRACTION_BITS) + ZW'(5);
    q1  = (2*ZW)'(v1) * (2*ZW)'(RecipTen);
    q2  = (2*ZW)'(v2) * (2*ZW)'(RecipTen);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
    m1_r <= m1c;
    m2_r <= m2c;
    // Division by ten through multiplication by the scaled reciprocal.
    z1_r <= ZW'(q1 >> (FRACTION_BITS + 13));
    z2_r <= ZW'(q2 >> (FRACTION_BITS + 13));
    f1_r <= {in_item.first_north, in_item.first_east};
    f2_r <= {in_item.second_north, in_item.second_east};
  end

  // Stage 2: gain-scaled start value, x = (mag*2^F*K + 2^23) >> 24.
  logic          s2_vld_r;
  logic [W-1:0]  x1s_r, x2s_r;
  logic [ZW-1:0] z1s_r, z2s_r;
  logic [1:0]    f1s_r, f2s_r;
  logic [37:0]   p1, p2;

  assign p1 = 38'(m1_r) * 38'(cvs_pkg::GainQ24);
  assign p2 = 38'(m2_r) * 38'(cvs_pkg::GainQ24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    x1s_r <= W'(((PW'(p1) << FRACTION_BITS) + (PW'(1) << 23)) >> 24);
    x2s_r <= W'(((PW'(p2) << FRACTION_BITS) + (PW'(1) << 23)) >> 24);
    z1s_r <= z1_r;
    z2s_r <= z2_r;
    f1s_r <= f1_r;
    f2s_r <= f2_r;
  end

  // Rotation rows, one per vector; the flags ride in the sideband.
  logic                 r1_vld, r2_vld;
  logic signed [W-1:0]  rx1, ry1, rx2, ry2;
  logic signed [ZW-1:0] rz1, rz2;
  logic [1:0]           rf1, rf2;

  cvs_chain #(.STAGES(NST), .FBITS(FRACTION_BITS), .W(W), .ZW(ZW), .SB(2),
              .VECT(1'b0)) u_rot1 (
    .clk(clk), .rst_n(rst_n), .vld_in(s2_vld_r), .x_in(x1s_r), .y_in('0),
    .z_in(z1s_r), .sb_in(f1s_r), .vld_out(r1_vld), .x_out(rx1), .y_out(ry1),
    .z_out(rz1), .sb_out(rf1)
  );
  cvs_chain #(.STAGES(NST), .FBITS(FRACTION_BITS), .W(W), .ZW(ZW), .SB(2),
              .VECT(1'b0)) u_rot2 (
    .clk(clk), .rst_n(rst_n), .vld_in(s2_vld_r), .x_in(x2s_r), .y_in('0),
    .z_in(z2s_r), .sb_in(f2s_r), .vld_out(r2_vld), .x_out(rx2), .y_out(ry2),
    .z_out(rz2), .sb_out(rf2)
  );

  // Stage 3: signed sum of components.
  logic                s3_vld_r;
  logic signed [W-1:0] sx_r, sy_r;
  logic signed [W-1:0] cx1, cy1, cx2, cy2;

  always_comb begin
    cx1 = rf1[0] ? rx1 : -rx1;
    cy1 = rf1[1] ? ry1 : -ry1;
    cx2 = rf2[0] ? rx2 : -rx2;
    cy2 = rf2[1] ? ry2 : -ry2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= r1_vld;
    end
    sx_r <= cx1 + cx2;
    sy_r <= cy1 + cy2;
  end

  // Stage 4: absolute values and flags for the vectoring row.
  logic                s4_vld_r;
  logic signed [W-1:0] ax_r, ay_r;
  logic [3:0]          fl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    ax_r <= sx_r[W-1] ? -sx_r : sx_r;
    ay_r <= sy_r[W-1] ? -sy_r : sy_r;
    // Flags: y not negative, x not negative, x zero, y zero.
    fl_r <= {!sy_r[W-1], !sx_r[W-1], sx_r == '0, sy_r == '0};
  end

  logic                 v_vld;
  logic signed [W-1:0]  vx, vy;
  logic signed [ZW-1:0] vz;
  logic [3:0]           vf;

  cvs_chain #(.STAGES(NST), .FBITS(FRACTION_BITS), .W(W), .ZW(ZW), .SB(4),
              .VECT(1'b1)) u_vec (
    .clk(clk), .rst_n(rst_n), .vld_in(s4_vld_r), .x_in(ax_r), .y_in(ay_r),
    .z_in('0), .sb_in(fl_r), .vld_out(v_vld), .x_out(vx), .y_out(vy),
    .z_out(vz), .sb_out(vf)
  );

  // The vectoring row adds the stage angle whenever it rotates y downwards,
  // so its accumulated angle is already the angle of the sum.
  // Stage 5: gain correction of magnitude, angle clamp.
  logic              s5_vld_r;
  logic [PW-1:0]     mq_r;
  logic [ZW-1:0]     zc_r;
  logic [3:0]        f5_r;
  logic signed [ZW-1:0] zn;
  logic [ZW-1:0]     zmax;

  assign zn   = vz;
  assign zmax = ZW'(90) << FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= v_vld;
    end
    mq_r <= (PW'(unsigned'(vx)) * PW'(cvs_pkg::GainQ24) + (PW'(1) << 23)) >> 24;
    if (zn < 0) begin
      zc_r <= '0;
    end else if (ZW'(zn) > zmax) begin
      zc_r <= zmax;
    end else begin
      zc_r <= ZW'(zn);
    end
    f5_r <= vf;
  end

  // Stage 6: scale to thousandths.
  logic          s6_vld_r;
  logic [PW-1:0] mag6_r;
  logic [ZW+9:0] ang6_r;
  logic [3:0]    f6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    mag6_r <= (mq_r * PW'(10) + (PW'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    ang6_r <= ((ZW+10)'(zc_r) * (ZW+10)'(1000) + ((ZW+10)'(1) << (FRACTION_BITS - 1)))
              >> FRACTION_BITS;
    f6_r   <= f5_r;
  end

  // Output register.
  logic                 out_valid_r;
  cvs_pkg::out_item_t   out_item_r, res;

  always_comb begin
    res.sum_magnitude = (mag6_r > PW'(cvs_pkg::MagOutMax)) ? 18'(cvs_pkg::MagOutMax)
                                                           : mag6_r[17:0];
    res.sum_north = f6_r[3];
    res.sum_east  = f6_r[2];
    if (f6_r[1] && f6_r[0]) begin
      res.sum_magnitude = '0;
      res.sum_angle     = '0;
      res.sum_north     = 1'b1;
      res.sum_east      = 1'b1;
    end else if (f6_r[1]) begin
      res.sum_angle = 17'd90000;
    end else if (f6_r[0]) begin
      res.sum_angle = '0;
    end else begin
      res.sum_angle = ang6_r[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s6_vld_r;
    end
    out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CVS_ASSERT_NEXT(a_out_follows, clk, rst_n, s6_vld_r, out_valid, "lost result item")
  `CVS_ASSERT_NEXT(a_no_phantom, clk, rst_n, !s6_vld_r, !out_valid, "invented result item")
  `CVS_ASSERT_NOW(a_rows_aligned, clk, rst_n, r1_vld || r2_vld, r1_vld && r2_vld,
                  "rotation rows out of step")
endmodule
`default_nettype wire
